### hdl/voice_effect_sample_chain_defines.svh
// Assertion macros shared by the checker of the voice effect sample chain.
// Depends on nothing; included by the checker file.
`ifndef VOICE_EFFECT_SAMPLE_CHAIN_DEFINES_SVH
`define VOICE_EFFECT_SAMPLE_CHAIN_DEFINES_SVH
`define VESC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VESC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/vesc_pkg.sv
// Package for the voice effect sample chain: widths, register indexes, states.
// Depends on nothing.
`default_nettype none
package vesc_pkg;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int CoefW = 20;
   localparam int DelayW = 48;
   localparam logic [2:0] CSR_MODE = 3'd0;
   localparam logic [2:0] CSR_B0 = 3'd1;
   localparam logic [2:0] CSR_B1 = 3'd2;
   localparam logic [2:0] CSR_B2 = 3'd3;
   localparam logic [2:0] CSR_A1 = 3'd4;
   localparam logic [2:0] CSR_A2 = 3'd5;
   localparam logic [2:0] CSR_STEP = 3'd6;
   localparam logic [1:0] MODE_BYPASS = 2'd0;
   localparam logic [1:0] MODE_LOWPASS = 2'd1;
   localparam logic [1:0] MODE_HIGHPASS = 2'd2;
   localparam logic [1:0] MODE_RING = 2'd3;
   localparam logic [15:0] LEVEL_ALPHA = 16'd3277;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DC, ST_GAIN, ST_LVL, ST_B0, ST_A1, ST_A2, ST_B1, ST_B2, ST_FIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [CoefW-1:0] coef;
      logic signed [DelayW-1:0] data;
   } mul_req_type;
endpackage
`default_nettype wire

### hdl/vesc_mul.sv
// Shared registered signed multiplier, 20 x 48 bit operands, truncated product.
// Depends on vesc_pkg.
`default_nettype none
module vesc_mul (
   input  wire logic clock,
   input  wire vesc_pkg::mul_req_type mul_req,
   output logic signed [63:0] mul_prod_ff
);
   import vesc_pkg::*;
   logic signed [63:0] mul_prod_in;
   assign mul_prod_in = 64'(mul_req.coef) * 64'(mul_req.data);
   always_ff @(posedge clock) begin
      mul_prod_ff <= mul_prod_in;
   end
endmodule
`default_nettype wire

### hdl/voice_effect_sample_chain.sv
// Top level of the voice effect sample chain: sequencer, state and config.
// Depends on vesc_pkg and vesc_mul.
//  channel | dir | beat
//  req_    | in  | adc_sample, adc_fresh
//  rsp_    | out | effect_sample, conditioned_sample, level
//  csr_    | in  | index, data
// Bypass and ring modes pass ST_DC, ST_GAIN and ST_LVL; the result is valid in ST_OUT.
// The biquad modes add six steps, ST_B0 through ST_FIN, between ST_LVL and ST_OUT.
// After the result beat the block returns to idle, where the next request beat is taken.
// Reset is synchronous, clears the sequencer and filter state, and loads default config.
// A stalled result holds the block; no new request beat is taken until it leaves.
`default_nettype none
module voice_effect_sample_chain
   import vesc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [15:0] req_adc_sample,
   input  wire logic req_adc_fresh,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_effect_sample,
   output logic signed [15:0] rsp_conditioned_sample,
   output logic [15:0] rsp_level,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import vesc_pkg::*;
   localparam logic signed [63:0] YLim = 64'sd1 <<< (15 + COEF_FRAC_BITS);
   localparam logic signed [63:0] DMax = (64'sd1 <<< 47) - 64'sd1;
   localparam logic signed [63:0] DMin = -(64'sd1 <<< 47);

   state_type state_ff, state_in;
   logic [1:0] mode_ff;
   logic signed [CoefW-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [31:0] step_ff, phase_ff;
   logic [15:0] held_ff;
   logic signed [15:0] dcin_ff;
   logic signed [31:0] dcout_ff;
   logic signed [DelayW-1:0] z1_ff, z2_ff;
   logic [31:0] lvl_ff;
   logic signed [15:0] c_ff, e_ff;
   logic signed [63:0] yf_ff, yc_ff, acc1_ff, acc2_ff;
   mul_req_type mul_req;
   logic signed [63:0] prod;
   logic signed [63:0] dy, cy, z1n, z2n, ybq, lvld;
   logic signed [15:0] xs;
   logic signed [16:0] cneg;

   vesc_mul u_mul (.clock(clock), .mul_req(mul_req), .mul_prod_ff(prod));

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_effect_sample = e_ff;
   assign rsp_conditioned_sample = c_ff;
   assign rsp_level = lvl_ff[31:16];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DC;
         ST_DC: state_in = ST_GAIN;
         ST_GAIN: state_in = ST_LVL;
         ST_LVL: state_in = (mode_ff == MODE_BYPASS || mode_ff == MODE_RING) ? ST_OUT : ST_B0;
         ST_B0: state_in = ST_A1;
         ST_A1: state_in = ST_A2;
         ST_A2: state_in = ST_B1;
         ST_B1: state_in = ST_B2;
         ST_B2: state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_req.coef = '0;
      mul_req.data = '0;
      case (state_ff)
         ST_GAIN: begin
            mul_req.coef = CoefW'($signed({1'b0, LEVEL_ALPHA}));
            mul_req.data = DelayW'($signed({1'b0, (c_ff < 0) ? -17'(c_ff) : 17'(c_ff), 16'd0}))
               - DelayW'($signed({1'b0, lvl_ff}));
         end
         ST_LVL: begin
            mul_req.coef = b0_ff;
            mul_req.data = DelayW'(c_ff);
         end
         ST_B0: begin
            mul_req.coef = b1_ff;
            mul_req.data = DelayW'(c_ff);
         end
         ST_A1: begin
            mul_req.coef = a1_ff;
            mul_req.data = DelayW'(yc_ff);
         end
         ST_A2: begin
            mul_req.coef = a2_ff;
            mul_req.data = DelayW'(yc_ff);
         end
         ST_B1: begin
            mul_req.coef = b2_ff;
            mul_req.data = DelayW'(c_ff);
         end
         default: ;
      endcase
   end

   assign xs = $signed(held_ff ^ 16'h8000);
   assign dy = 64'(xs) - 64'(dcin_ff) + 64'(dcout_ff) - (64'(dcout_ff) >>> 8);
   assign cy = (dy > 64'sd8191) ? 64'sd32767 : (dy < -64'sd8192) ? -64'sd32768 : dy * 4;
   assign lvld = prod >>> 16;
   assign cneg = -17'(c_ff);
   assign ybq = (yf_ff >= 0) ? (yf_ff >>> COEF_FRAC_BITS) : -((-yf_ff) >>> COEF_FRAC_BITS);
   assign z1n = acc1_ff - (prod >>> COEF_FRAC_BITS);
   assign z2n = acc2_ff + prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_BYPASS;
         b0_ff <= CoefW'(64'sd1 <<< COEF_FRAC_BITS);
         b1_ff <= '0; b2_ff <= '0; a1_ff <= '0; a2_ff <= '0;
         step_ff <= 32'd16106127;
         held_ff <= 16'h8000;
         dcin_ff <= '0; dcout_ff <= '0;
         z1_ff <= '0; z2_ff <= '0;
         phase_ff <= '0; lvl_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE: mode_ff <= csr_data[1:0];
               CSR_B0: b0_ff <= csr_data[CoefW-1:0];
               CSR_B1: b1_ff <= csr_data[CoefW-1:0];
               CSR_B2: b2_ff <= csr_data[CoefW-1:0];
               CSR_A1: a1_ff <= csr_data[CoefW-1:0];
               CSR_A2: a2_ff <= csr_data[CoefW-1:0];
               CSR_STEP: step_ff <= csr_data;
               default: ;
            endcase
            if (csr_index inside {[CSR_B0:CSR_A2]}) begin
               z1_ff <= '0;
               z2_ff <= '0;
            end
         end
         case (state_ff)
            ST_IDLE: if (req_valid && req_adc_fresh) held_ff <= req_adc_sample;
            ST_DC: begin
               dcin_ff <= xs;
               dcout_ff <= (dy > 64'sd2147483647) ? 32'sh7fffffff :
                  (dy < -64'sd2147483648) ? 32'sh80000000 : 32'(dy);
               c_ff <= 16'(cy);
            end
            ST_LVL: begin
               lvl_ff <= lvl_ff + 32'(lvld);
               if (mode_ff == MODE_BYPASS) e_ff <= c_ff;
               if (mode_ff == MODE_RING) begin
                  phase_ff <= phase_ff + step_ff;
                  if (((phase_ff + step_ff) & 32'h80000000) != 0) e_ff <= c_ff;
                  else e_ff <= (cneg == 17'sd32768) ? 16'sh7fff : 16'(cneg);
               end
            end
            ST_B0: begin
               yf_ff <= prod + 64'(z1_ff);
               yc_ff <= (prod + 64'(z1_ff) >= YLim) ? YLim - 64'sd1 :
                  (prod + 64'(z1_ff) < -YLim) ? -YLim : prod + 64'(z1_ff);
            end
            ST_A1: acc1_ff <= 64'(z2_ff) + prod;
            ST_A2: z1_ff <= (z1n > DMax) ? DelayW'(DMax) : (z1n < DMin) ? DelayW'(DMin)
               : DelayW'(z1n);
            ST_B1: acc2_ff <= -(prod >>> COEF_FRAC_BITS);
            ST_B2: z2_ff <= (z2n > DMax) ? DelayW'(DMax) : (z2n < DMin) ? DelayW'(DMin)
               : DelayW'(z2n);
            ST_FIN: e_ff <= (ybq > 64'sd32767) ? 16'sh7fff : (ybq < -64'sd32768) ? 16'sh8000
               : 16'(ybq);
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/vesc_checker.sv
// Port checker for the voice effect sample chain, bound to the top level.
// Depends on voice_effect_sample_chain_defines.svh and the top level's ports.
`default_nettype none
`include "voice_effect_sample_chain_defines.svh"
module vesc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic csr_ready,
   input wire logic [15:0] rsp_level
);
   `VESC_ASSERT(a_no_req_busy, clock, reset, rsp_valid |-> !req_ready, "req ready while result waits")
   `VESC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")
   `VESC_ASSERT(a_accept_busy, clock, reset, req_valid && req_ready |=> !req_ready && !rsp_valid, "no gap after accept")
   `VESC_ASSERT(a_level_max, clock, reset, rsp_valid |-> rsp_level <= 16'd32768, "level out of range")
   `VESC_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && csr_ready, "not idle after reset")
endmodule
bind voice_effect_sample_chain vesc_checker u_vesc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .csr_ready(csr_ready),
   .rsp_level(rsp_level)
);
`default_nettype wire
